// ===== design/huffman_tree_string_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Huffman tree string decoder assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_STRING_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TREE_STRING_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define HTSD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define HTSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define HTSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HTSD_ASSERT(lbl, expr, msg)

`define HTSD_ASSERT_IMPL(lbl, ante, cons, msg)

`define HTSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/htsd_pkg.sv =====
// ----------------------------------------------------------------------------
// htsd_pkg
// Shared types and constants of the Huffman tree string decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htsd_pkg;

    localparam int TREE_NODES_DEF = 256;
    localparam int BITS_PER_BYTE  = 8;
    localparam int IDX_W          = 9;
    localparam int WORD_W         = 16;
    localparam int CHAR_W         = 8;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 8;
    localparam int M_TUSER_W      = 2;

    localparam logic [WORD_W-1:0] ROOT_NODE = 16'h0100;
    localparam logic [WORD_W-1:0] LEAF_MAX  = 16'h00FF;

    typedef enum logic
    {
        ACT_WRITE = 1'b0,
        ACT_FEED  = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } walk_state_t;

    typedef struct packed
    {
        logic [CHAR_W-1:0] character;
        logic              eos;
        logic              bad;
    } result_t;

    typedef struct packed
    {
        logic    push;
        logic    flush;
        result_t res;
    } res_ctl_t;

    typedef struct packed
    {
        logic pend_valid;
        logic space;
    } res_sts_t;

endpackage

// ===== design/htsd_tree_ram.sv =====
// ----------------------------------------------------------------------------
// htsd_tree_ram
// Tree child word store, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htsd_tree_ram
    import htsd_pkg::*;
#(
    parameter int DEPTH  = 2 * TREE_NODES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/htsd_walker.sv =====
// ----------------------------------------------------------------------------
// htsd_walker
// Bit sequencer: one tree lookup and child compare per stream bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htsd_walker
    import htsd_pkg::*;
#(
    parameter int TREE_NODES = TREE_NODES_DEF,
    parameter int NODE_W     = $clog2(TREE_NODES),
    parameter int ADDR_W     = NODE_W + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              action,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [WORD_W-1:0] entry_value,
    input  logic [7:0]        stream_byte,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [WORD_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [WORD_W-1:0] ram_rdata,
    output res_ctl_t          ctl,
    input  res_sts_t          sts
);

    localparam logic [IDX_W:0]  IDX_LIMIT = (IDX_W + 1)'(2 * TREE_NODES);
    localparam logic [WORD_W-1:0] NODE_LIMIT = WORD_W'(TREE_NODES);
    localparam logic [2:0]      CNT_LAST  = 3'(BITS_PER_BYTE - 1);

    walk_state_t       state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [7:0]        shift_reg, shift_next;
    logic [2:0]        cnt_reg, cnt_next;

    logic              accept;
    logic              is_leaf;
    logic              is_bad;
    logic              is_eos;
    logic              has_result;
    logic              stall;
    logic              byte_done;
    logic [WORD_W-1:0] offset;
    logic [NODE_W-1:0] child_node;

    assign accept     = s_tvalid && s_tready;
    assign offset     = ram_rdata - ROOT_NODE;
    assign is_leaf    = ram_rdata <= LEAF_MAX;
    assign is_bad     = !is_leaf && (offset >= NODE_LIMIT);
    assign is_eos     = is_leaf && (ram_rdata[CHAR_W-1:0] == '0);
    assign has_result = is_leaf || is_bad;
    assign child_node = has_result ? '0 : offset[NODE_W-1:0];
    assign stall      = has_result && sts.pend_valid && !sts.space;
    assign byte_done  = is_eos || (cnt_reg == CNT_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_FEED))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stall && byte_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid || sts.space)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = entry_index[ADDR_W-1:0];
        ram_wdata     = entry_value;
        ram_re        = 1'b0;
        ram_raddr     = {node_reg, stream_byte[0]};
        ctl.push      = 1'b0;
        ctl.flush     = 1'b0;
        ctl.res.character = is_bad ? '0 : ram_rdata[CHAR_W-1:0];
        ctl.res.eos   = is_eos;
        ctl.res.bad   = is_bad;
        node_next     = node_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (action == ACT_WRITE))
                begin
                    ram_we = {1'b0, entry_index} < IDX_LIMIT;
                end
                if (s_tvalid && (action == ACT_FEED))
                begin
                    ram_re     = 1'b1;
                    shift_next = stream_byte;
                    cnt_next   = '0;
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    ctl.push   = has_result;
                    node_next  = child_node;
                    ram_raddr  = {child_node, shift_reg[1]};
                    ram_re     = !byte_done;
                    shift_next = shift_reg >> 1;
                    cnt_next   = cnt_reg + 3'd1;
                end
            end
            ST_FLUSH:
            begin
                ctl.flush = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            node_reg  <= '0;
            shift_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/htsd_result_stage.sv =====
// ----------------------------------------------------------------------------
// htsd_result_stage
// Pending result slot and output register; marks the final result of a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htsd_result_stage
    import htsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  res_ctl_t             ctl,
    output res_sts_t             sts,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    result_t pend_reg;
    logic    pend_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_last_reg;
    logic    space;
    logic    move;

    assign space = !out_valid_reg || m_tready;
    assign move  = pend_valid_reg && space && (ctl.push || ctl.flush);

    assign sts.pend_valid = pend_valid_reg;
    assign sts.space      = space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            pend_reg <= ctl.res;
        end
        if (move)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= ctl.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.character;
    assign m_tuser  = {out_reg.bad, out_reg.eos};
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/huffman_tree_string_decoder_top.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_string_decoder_top
// Bit-serial Huffman tree string decoder with a loadable tree store.
//
// Channel  Dir  Fields
// s_*      in   tdata: entry_index, entry_value, stream_byte; tuser: action
// m_*      out  tdata: character; tuser: end_of_string, bad_node; tlast: last
//
// Tree writes and stream bytes are taken only while idle. A stream byte
// walks up to 8 bits, fewer on an end of string: one lookup per bit through
// the registered read port of the tree store, then a flush state releases
// the final result. Output stalls hold the walk. The tree store has no reset and
// must be written before it is walked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_tree_string_decoder_top_assert.svh"

module huffman_tree_string_decoder_top
    import htsd_pkg::*;
#(
    parameter int TREE_NODES = TREE_NODES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [8:0] entry_index, [24:9] entry_value, [32:25] stream_byte, [39:33] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] character
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] end_of_string, [1] bad_node
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int NODE_W = $clog2(TREE_NODES);
    localparam int ADDR_W = NODE_W + 1;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    res_ctl_t          ctl;
    res_sts_t          sts;

    htsd_tree_ram
    #(
        .DEPTH  (2 * TREE_NODES),
        .ADDR_W (ADDR_W)
    )
    u_tree_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htsd_walker
    #(
        .TREE_NODES (TREE_NODES),
        .NODE_W     (NODE_W),
        .ADDR_W     (ADDR_W)
    )
    u_walker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .action      (s_tuser),
        .entry_index (s_tdata[8:0]),
        .entry_value (s_tdata[24:9]),
        .stream_byte (s_tdata[32:25]),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .ctl         (ctl),
        .sts         (sts)
    );

    htsd_result_stage u_result_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `HTSD_ASSERT(a_push_flush_excl, !(ctl.push && ctl.flush), "push and flush together")
    `HTSD_ASSERT_IMPL(a_push_space, ctl.push && sts.pend_valid, sts.space, "push without space")
    `HTSD_ASSERT_IMPL(a_idle_no_pend, s_tready, !sts.pend_valid, "result pending while idle")
    `HTSD_ASSERT_NEXT(a_feed_busy, s_tvalid && s_tready && s_tuser, !s_tready, "ready after feed")

endmodule
